/* sv/lc3_pkg.sv */
// Package with shared types, constants and codes of the LC-3 executor.
`timescale 1ns / 1ps
package lc3_pkg;
   localparam int AddrBitsDefault = 16;
   localparam logic [15:0] RegReset = 16'h7777;
   localparam logic [15:0] PcReset  = 16'h3000;
   localparam logic [2:0]  CcN = 3'b100;
   localparam logic [2:0]  CcZ = 3'b010;
   localparam logic [2:0]  CcP = 3'b001;
   localparam logic [7:0]  HaltVector = 8'h25;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_EXEC  = 2'd2;

   localparam logic [3:0] OPC_BR   = 4'b0000;
   localparam logic [3:0] OPC_ADD  = 4'b0001;
   localparam logic [3:0] OPC_LD   = 4'b0010;
   localparam logic [3:0] OPC_ST   = 4'b0011;
   localparam logic [3:0] OPC_JSR  = 4'b0100;
   localparam logic [3:0] OPC_AND  = 4'b0101;
   localparam logic [3:0] OPC_LDR  = 4'b0110;
   localparam logic [3:0] OPC_STR  = 4'b0111;
   localparam logic [3:0] OPC_NOT  = 4'b1001;
   localparam logic [3:0] OPC_LDI  = 4'b1010;
   localparam logic [3:0] OPC_STI  = 4'b1011;
   localparam logic [3:0] OPC_JMP  = 4'b1100;
   localparam logic [3:0] OPC_LEA  = 4'b1110;
   localparam logic [3:0] OPC_TRAP = 4'b1111;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [15:0] data;
   } req_type;

   typedef struct packed {
      logic [15:0] reg0;
      logic [15:0] reg1;
      logic [15:0] reg2;
      logic [15:0] reg3;
      logic [15:0] reg4;
      logic [15:0] reg5;
      logic [15:0] reg6;
      logic [15:0] reg7;
      logic [15:0] program_counter;
      logic [2:0]  cond_codes;
      logic        halted;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_DECODE, ST_INDIR, ST_DATA, ST_DONE
   } state_type;

   // Memory address select.
   typedef enum logic [1:0] {
      MA_LOAD, MA_PC, MA_EFF, MA_MDR
   } maddr_type;

   typedef struct packed {
      logic      load_req;   // capture request payload
      logic      mem_en;     // read the memory
      logic      mem_we;     // write the memory
      maddr_type mem_sel;
      logic      take_ir;    // latch fetched word, PC + 1
      logic      exec;       // register/PC update of decoded instruction
      logic      wb_mem;     // load result into DR, set CC
      logic      start;      // PC = origin, CC = Z, run
      logic      done;       // present result
   } ctrl_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       running;
      logic [3:0] opcode;
   } stat_type;
endpackage

/* sv/lc3_instruction_executor_top.sv */
// Top level of the LC-3 instruction executor.
`timescale 1ns / 1ps
// Usage: an item is transferred on req_payload at a rising edge with start high
// and busy low. Operation 0 writes a word to memory, 1 restarts at the origin
// held in the configuration register, 2 runs one instruction if running.
// Exactly one result per item appears on rsp_payload for one cycle with
// rsp_valid high; the receiver cannot stall, so it must take it then.
// States from the transfer to the result cycle: FETCH, DONE for load, start,
// unused code and a halted execute; FETCH, DECODE, DONE for instructions
// without data access; FETCH, DECODE, DATA, DONE for LD, LDR, ST and STR;
// FETCH, DECODE, INDIR, DATA, DONE for LDI and STI. The single-port memory
// sets this: fetch, pointer and data accesses run in sequence, one per cycle
// with registered read data. busy stays high from the transfer through the
// result cycle; the next item may be transferred at the edge that ends the
// cycle after the result.
// The origin register is written over csr_valid/csr_ready; csr_ready is high
// only while the block is idle. Reset clears registers to 0x7777, PC to
// 0x3000, CC to Z and halts the machine; memory content is undefined until
// loaded.
module lc3_instruction_executor_top #(
   parameter int AddrBits = lc3_pkg::AddrBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lc3_pkg::req_type req_payload,
   output logic             rsp_valid,
   output lc3_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   lc3_pkg::ctrl_type ctrl;
   lc3_pkg::stat_type stat;
   logic [15:0] origin_ff;

   // The origin register takes a write only while no item is in flight.
   assign csr_ready = ~busy;
   always_ff @(posedge clock) begin
      if (reset) origin_ff <= lc3_pkg::PcReset;
      else if (csr_valid && csr_ready) origin_ff <= csr_data;
   end

   lc3_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .ctrl(ctrl)
   );

   lc3_dp #(.AddrBits(AddrBits)) u_dp (
      .clock(clock), .reset(reset), .req(req_payload), .origin(origin_ff),
      .ctrl(ctrl), .stat(stat), .rsp(rsp_payload)
   );

   assign rsp_valid = ctrl.done;

`ifndef NO_ASSERTIONS
   // A result is only produced while an item is in flight.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without item");
   // After a result the block is free again.
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   // An accepted item never yields a result in the next cycle.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("early result");
`endif
endmodule

/* sv/lc3_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lc3_ram #(
   parameter int Width = 16,
   parameter int Depth = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem[addr] <= wdata;
         rdata <= mem[addr];
      end
   end
endmodule

/* sv/lc3_ctrl.sv */
// Sequencer for the LC-3 executor.
`timescale 1ns / 1ps
module lc3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lc3_pkg::stat_type  stat,
   output lc3_pkg::ctrl_type  ctrl
);
   lc3_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lc3_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lc3_pkg::ST_IDLE: if (start) state_in = lc3_pkg::ST_FETCH;
         lc3_pkg::ST_FETCH: begin
            if (stat.operation == lc3_pkg::OP_EXEC && stat.running)
               state_in = lc3_pkg::ST_DECODE;
            else state_in = lc3_pkg::ST_DONE;
         end
         lc3_pkg::ST_DECODE: begin
            unique case (stat.opcode)
               lc3_pkg::OPC_LDI, lc3_pkg::OPC_STI: state_in = lc3_pkg::ST_INDIR;
               lc3_pkg::OPC_LD, lc3_pkg::OPC_LDR, lc3_pkg::OPC_ST,
               lc3_pkg::OPC_STR: state_in = lc3_pkg::ST_DATA;
               default: state_in = lc3_pkg::ST_DONE;
            endcase
         end
         lc3_pkg::ST_INDIR: state_in = lc3_pkg::ST_DATA;
         lc3_pkg::ST_DATA: state_in = lc3_pkg::ST_DONE;
         lc3_pkg::ST_DONE: state_in = lc3_pkg::ST_IDLE;
         default: state_in = lc3_pkg::ST_IDLE;
      endcase
   end

   // ST_FETCH: op is known from the captured request; memory access issued here for a load or a running execute.
   always_comb begin
      ctrl = '0;
      ctrl.mem_sel = lc3_pkg::MA_PC;
      busy = (state_ff != lc3_pkg::ST_IDLE);
      unique case (state_ff)
         lc3_pkg::ST_IDLE: ctrl.load_req = start;
         lc3_pkg::ST_FETCH: begin
            unique case (stat.operation)
               lc3_pkg::OP_LOAD: begin
                  ctrl.mem_en = 1'b1;
                  ctrl.mem_we = 1'b1;
                  ctrl.mem_sel = lc3_pkg::MA_LOAD;
               end
               lc3_pkg::OP_START: ctrl.start = 1'b1;
               lc3_pkg::OP_EXEC: ctrl.mem_en = stat.running;
               default: ;
            endcase
         end
         lc3_pkg::ST_DECODE: begin
            ctrl.take_ir = 1'b1;
            unique case (stat.opcode)
               lc3_pkg::OPC_LD, lc3_pkg::OPC_LDI, lc3_pkg::OPC_STI: begin
                  ctrl.mem_en = 1'b1;
                  ctrl.mem_sel = lc3_pkg::MA_EFF;
               end
               lc3_pkg::OPC_LDR: begin
                  ctrl.mem_en = 1'b1;
                  ctrl.mem_sel = lc3_pkg::MA_EFF;
               end
               lc3_pkg::OPC_ST, lc3_pkg::OPC_STR: begin
                  ctrl.mem_en = 1'b1;
                  ctrl.mem_we = 1'b1;
                  ctrl.mem_sel = lc3_pkg::MA_EFF;
               end
               default: ctrl.exec = 1'b1;
            endcase
         end
         lc3_pkg::ST_INDIR: begin
            ctrl.mem_en = 1'b1;
            ctrl.mem_we = (stat.opcode == lc3_pkg::OPC_STI);
            ctrl.mem_sel = lc3_pkg::MA_MDR;
         end
         lc3_pkg::ST_DATA: ctrl.wb_mem = (stat.opcode == lc3_pkg::OPC_LD) ||
                                         (stat.opcode == lc3_pkg::OPC_LDI) ||
                                         (stat.opcode == lc3_pkg::OPC_LDR);
         lc3_pkg::ST_DONE: ctrl.done = 1'b1;
         default: ;
      endcase
   end
endmodule

/* sv/lc3_dp.sv */
// Datapath of the LC-3 executor: registers, PC, condition codes and memory.
`timescale 1ns / 1ps
module lc3_dp #(
   parameter int AddrBits = lc3_pkg::AddrBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  lc3_pkg::req_type  req,
   input  logic [15:0]       origin,
   input  lc3_pkg::ctrl_type ctrl,
   output lc3_pkg::stat_type stat,
   output lc3_pkg::rsp_type  rsp
);
   lc3_pkg::req_type req_ff;
   logic [15:0] rf_ff [8];
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  cc_ff;
   logic        run_ff;
   logic [15:0] ir_ff;
   logic        fetched_ff;
   logic [15:0] rdata;
   logic [15:0] ir, eff, wb_val, alu_b, alu_v, br_pc;
   logic [AddrBits-1:0] maddr;
   logic [2:0] dr, sr1;

   // The cycle after an instruction fetch has the fetched word on rdata;
   // later states use ir_ff.
   assign ir  = fetched_ff ? rdata : ir_ff;
   assign dr  = ir[11:9];
   assign sr1 = ir[8:6];
   assign pc_in = pc_ff + 16'd1;

   always_comb begin
      if (ir[15:12] == lc3_pkg::OPC_LDR || ir[15:12] == lc3_pkg::OPC_STR)
         eff = rf_ff[sr1] + {{10{ir[5]}}, ir[5:0]};
      else
         eff = pc_in + {{7{ir[8]}}, ir[8:0]};
   end

   always_comb begin
      unique case (ctrl.mem_sel)
         lc3_pkg::MA_LOAD: maddr = req_ff.address[AddrBits-1:0];
         lc3_pkg::MA_PC:   maddr = pc_ff[AddrBits-1:0];
         lc3_pkg::MA_EFF:  maddr = eff[AddrBits-1:0];
         default:          maddr = rdata[AddrBits-1:0];
      endcase
   end

   lc3_ram #(.Width(16), .Depth(2 ** AddrBits)) u_mem (
      .clock(clock), .en(ctrl.mem_en), .we(ctrl.mem_we), .addr(maddr),
      .wdata((ctrl.mem_sel == lc3_pkg::MA_LOAD) ? req_ff.data : rf_ff[dr]),
      .rdata(rdata)
   );

   assign alu_b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_ff[ir[2:0]];
   assign alu_v = (ir[15:12] == lc3_pkg::OPC_ADD) ? rf_ff[sr1] + alu_b
                                                 : rf_ff[sr1] & alu_b;
   assign br_pc = pc_in + {{7{ir[8]}}, ir[8:0]};

   function automatic logic [2:0] cc_of(input logic [15:0] v);
      if (v[15]) return lc3_pkg::CcN;
      else if (v == 16'd0) return lc3_pkg::CcZ;
      else return lc3_pkg::CcP;
   endfunction

   assign wb_val = rdata;

   always_ff @(posedge clock) begin
      if (ctrl.load_req) req_ff <= req;
      if (ctrl.take_ir) ir_ff <= rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) rf_ff[i] <= lc3_pkg::RegReset;
         pc_ff  <= lc3_pkg::PcReset;
         cc_ff  <= lc3_pkg::CcZ;
         run_ff <= 1'b0;
         fetched_ff <= 1'b0;
      end else begin
         fetched_ff <= ctrl.mem_en && !ctrl.mem_we && (ctrl.mem_sel == lc3_pkg::MA_PC);
         if (ctrl.start) begin
            pc_ff  <= origin;
            cc_ff  <= lc3_pkg::CcZ;
            run_ff <= 1'b1;
         end
         if (ctrl.take_ir) pc_ff <= pc_in;
         if (ctrl.exec) begin
            unique case (ir[15:12])
               lc3_pkg::OPC_ADD, lc3_pkg::OPC_AND: begin
                  rf_ff[dr] <= alu_v;
                  cc_ff <= cc_of(alu_v);
               end
               lc3_pkg::OPC_NOT: begin
                  rf_ff[dr] <= ~rf_ff[sr1];
                  cc_ff <= cc_of(~rf_ff[sr1]);
               end
               lc3_pkg::OPC_BR: if ((dr & cc_ff) != 3'd0) pc_ff <= br_pc;
               lc3_pkg::OPC_JMP: pc_ff <= rf_ff[sr1];
               lc3_pkg::OPC_JSR: begin
                  rf_ff[7] <= pc_in;
                  pc_ff <= ir[11] ? pc_in + {{5{ir[10]}}, ir[10:0]} : rf_ff[sr1];
               end
               lc3_pkg::OPC_LEA: rf_ff[dr] <= br_pc;
               lc3_pkg::OPC_TRAP: if (ir[7:0] == lc3_pkg::HaltVector) run_ff <= 1'b0;
               default: ;
            endcase
         end
         if (ctrl.wb_mem) begin
            rf_ff[dr] <= wb_val;
            cc_ff <= cc_of(wb_val);
         end
      end
   end

   assign stat.operation = req_ff.operation;
   assign stat.running   = run_ff;
   assign stat.opcode    = ir[15:12];

   assign rsp.reg0 = rf_ff[0];
   assign rsp.reg1 = rf_ff[1];
   assign rsp.reg2 = rf_ff[2];
   assign rsp.reg3 = rf_ff[3];
   assign rsp.reg4 = rf_ff[4];
   assign rsp.reg5 = rf_ff[5];
   assign rsp.reg6 = rf_ff[6];
   assign rsp.reg7 = rf_ff[7];
   assign rsp.program_counter = pc_ff;
   assign rsp.cond_codes = cc_ff;
   assign rsp.halted = ~run_ff;
endmodule

/* tb/sv/lc3_instruction_executor_top_test.sv */
// Self-checking testbench for the LC-3 instruction executor top level.
`timescale 1ns / 1ps
// The testbench runs a directed program and then random programs under several
// origin settings. A predictor of the architectural state computes the result
// of every item when that item is queued. The driver and the monitor are
// clocked always blocks. Memory words that a step would read are loaded first,
// so the block never reads a word that was not written.
module lc3_instruction_executor_top_test;
   localparam int TimeoutCycles = 400000;
   localparam int RandomItems = 600;
   localparam logic [1:0] OpUnused = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lc3_pkg::req_type req_payload = '0;
   logic rsp_valid;
   lc3_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   lc3_instruction_executor_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Architectural state as the predictor sees it.
   logic [15:0] gpr [0:7];
   logic [15:0] pc_now;
   logic [2:0]  cc_now;
   bit          is_running;
   logic [15:0] origin;
   logic [15:0] mem_img [0:65535];
   bit          mem_known [0:65535];

   lc3_pkg::req_type pending_items[$];
   lc3_pkg::rsp_type expected_states[$];
   bit      failed = 1'b0;
   int      cycle_count = 0;
   int      hold_cycles = 0;
   int      queued_items = 0;

   function automatic logic [15:0] sign_extend(logic [15:0] v, int bits);
      logic signed [15:0] t;
      t = v << (16 - bits);
      return t >>> (16 - bits);
   endfunction

   function automatic logic [2:0] flags_of(logic [15:0] v);
      if (v[15]) return lc3_pkg::CcN;
      if (v == 16'd0) return lc3_pkg::CcZ;
      return lc3_pkg::CcP;
   endfunction

   // Advance the predicted state by one instruction.
   function automatic void run_instruction();
      logic [15:0] ir, eff, val, link;
      logic [2:0]  dr, sr1;
      ir = mem_img[pc_now];
      pc_now = pc_now + 16'd1;
      dr = ir[11:9];
      sr1 = ir[8:6];
      eff = pc_now + sign_extend(ir, 9);
      case (ir[15:12])
         lc3_pkg::OPC_ADD, lc3_pkg::OPC_AND: begin
            val = ir[5] ? sign_extend(ir, 5) : gpr[ir[2:0]];
            val = (ir[15:12] == lc3_pkg::OPC_ADD) ? gpr[sr1] + val : gpr[sr1] & val;
            gpr[dr] = val;
            cc_now = flags_of(val);
         end
         lc3_pkg::OPC_NOT: begin
            gpr[dr] = ~gpr[sr1];
            cc_now = flags_of(gpr[dr]);
         end
         lc3_pkg::OPC_BR: if ((ir[11:9] & cc_now) != 3'd0) pc_now = eff;
         lc3_pkg::OPC_JMP: pc_now = gpr[sr1];
         lc3_pkg::OPC_JSR: begin
            // The base register is read before the link register is written.
            link = ir[11] ? pc_now + sign_extend(ir, 11) : gpr[sr1];
            gpr[7] = pc_now;
            pc_now = link;
         end
         lc3_pkg::OPC_LD: begin
            gpr[dr] = mem_img[eff];
            cc_now = flags_of(gpr[dr]);
         end
         lc3_pkg::OPC_LDI: begin
            gpr[dr] = mem_img[mem_img[eff]];
            cc_now = flags_of(gpr[dr]);
         end
         lc3_pkg::OPC_LDR: begin
            gpr[dr] = mem_img[gpr[sr1] + sign_extend(ir, 6)];
            cc_now = flags_of(gpr[dr]);
         end
         lc3_pkg::OPC_LEA: gpr[dr] = eff;
         lc3_pkg::OPC_ST: begin
            mem_img[eff] = gpr[dr];
            mem_known[eff] = 1'b1;
         end
         lc3_pkg::OPC_STI: begin
            // The pointer is read once, before the store may overwrite it.
            val = mem_img[eff];
            mem_img[val] = gpr[dr];
            mem_known[val] = 1'b1;
         end
         lc3_pkg::OPC_STR: begin
            val = gpr[sr1] + sign_extend(ir, 6);
            mem_img[val] = gpr[dr];
            mem_known[val] = 1'b1;
         end
         lc3_pkg::OPC_TRAP: if (ir[7:0] == lc3_pkg::HaltVector) is_running = 1'b0;
         default: ;
      endcase
   endfunction

   // Apply one item to the predicted state and return the state it reports.
   function automatic lc3_pkg::rsp_type next_state(lc3_pkg::req_type item);
      lc3_pkg::rsp_type r;
      case (item.operation)
         lc3_pkg::OP_LOAD: begin
            mem_img[item.address] = item.data;
            mem_known[item.address] = 1'b1;
         end
         lc3_pkg::OP_START: begin
            pc_now = origin;
            cc_now = lc3_pkg::CcZ;
            is_running = 1'b1;
         end
         lc3_pkg::OP_EXEC: if (is_running) run_instruction();
         default: ;
      endcase
      r.reg0 = gpr[0]; r.reg1 = gpr[1]; r.reg2 = gpr[2]; r.reg3 = gpr[3];
      r.reg4 = gpr[4]; r.reg5 = gpr[5]; r.reg6 = gpr[6]; r.reg7 = gpr[7];
      r.program_counter = pc_now;
      r.cond_codes = cc_now;
      r.halted = !is_running;
      return r;
   endfunction

   task automatic queue_item(logic [1:0] op, logic [15:0] addr, logic [15:0] data);
      lc3_pkg::req_type item;
      item.operation = op;
      item.address = addr;
      item.data = data;
      pending_items = {pending_items, item};
      expected_states = {expected_states, next_state(item)};
      queued_items++;
   endtask

   function automatic logic [15:0] random_instruction();
      logic [3:0] opcodes [14];
      logic [15:0] w;
      opcodes = '{lc3_pkg::OPC_BR, lc3_pkg::OPC_ADD, lc3_pkg::OPC_LD, lc3_pkg::OPC_ST,
                  lc3_pkg::OPC_JSR, lc3_pkg::OPC_AND, lc3_pkg::OPC_LDR,
                  lc3_pkg::OPC_STR, lc3_pkg::OPC_NOT, lc3_pkg::OPC_LDI,
                  lc3_pkg::OPC_STI, lc3_pkg::OPC_JMP, lc3_pkg::OPC_LEA,
                  lc3_pkg::OPC_TRAP};
      w = 16'($urandom);
      if ($urandom_range(0, 19) != 0) w[15:12] = opcodes[$urandom_range(0, 13)];
      if (w[15:12] == lc3_pkg::OPC_TRAP && $urandom_range(0, 2) == 0)
         w[7:0] = lc3_pkg::HaltVector;
      return w;
   endfunction

   // Load any word that the coming instruction would read and that was never
   // written, then queue the execute itself.
   task automatic queue_execute();
      logic [15:0] ir, eff;
      if (is_running) begin
         if (!mem_known[pc_now]) queue_item(lc3_pkg::OP_LOAD, pc_now, random_instruction());
         ir = mem_img[pc_now];
         eff = pc_now + 16'd1 + sign_extend(ir, 9);
         case (ir[15:12])
            lc3_pkg::OPC_LD, lc3_pkg::OPC_LDI, lc3_pkg::OPC_STI:
               if (!mem_known[eff]) queue_item(lc3_pkg::OP_LOAD, eff, 16'($urandom));
            lc3_pkg::OPC_LDR: begin
               eff = gpr[ir[8:6]] + sign_extend(ir, 6);
               if (!mem_known[eff]) queue_item(lc3_pkg::OP_LOAD, eff, 16'($urandom));
            end
            default: ;
         endcase
         if (ir[15:12] == lc3_pkg::OPC_LDI && !mem_known[mem_img[eff]])
            queue_item(lc3_pkg::OP_LOAD, mem_img[eff], 16'($urandom));
      end
      queue_item(lc3_pkg::OP_EXEC, 16'($urandom), 16'($urandom));
   endtask

   // Place a chosen instruction at the PC and run it.
   task automatic run_word(logic [15:0] w);
      queue_item(lc3_pkg::OP_LOAD, pc_now, w);
      queue_execute();
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_states.size() != 0 || start || busy)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_origin(logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      origin = value;
      @(posedge clock);
      while (csr_valid) @(posedge clock);
   endtask

   // The configuration transfer ends at the edge where valid meets ready.
   always @(posedge clock) begin
      if (csr_valid && csr_ready) begin
         csr_valid <= 1'b0;
      end
   end

   // Driver: after each transfer it may hold start low for a randomly drawn hold-off before it offers the next item.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) hold_cycles = $urandom_range(0, 3);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            start <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_payload <= pending_items.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failed = 1'b1;
      end
   endtask

   // Monitor: each result is compared with the oldest predicted state.
   always @(posedge clock) begin
      lc3_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_states.size() == 0) begin
            $error("result with no item outstanding");
            failed = 1'b1;
         end else begin
            want = expected_states.pop_front();
            compare_field("reg0", want.reg0, rsp_payload.reg0);
            compare_field("reg1", want.reg1, rsp_payload.reg1);
            compare_field("reg2", want.reg2, rsp_payload.reg2);
            compare_field("reg3", want.reg3, rsp_payload.reg3);
            compare_field("reg4", want.reg4, rsp_payload.reg4);
            compare_field("reg5", want.reg5, rsp_payload.reg5);
            compare_field("reg6", want.reg6, rsp_payload.reg6);
            compare_field("reg7", want.reg7, rsp_payload.reg7);
            compare_field("program_counter", want.program_counter,
                          rsp_payload.program_counter);
            compare_field("cond_codes", want.cond_codes, rsp_payload.cond_codes);
            compare_field("halted", want.halted, rsp_payload.halted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TimeoutCycles) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [15:0] origins [4];
      int target, pick;
      for (int i = 0; i < 8; i++) gpr[i] = lc3_pkg::RegReset;
      pc_now = lc3_pkg::PcReset;
      cc_now = lc3_pkg::CcZ;
      is_running = 1'b0;
      origin = lc3_pkg::PcReset;
      for (int a = 0; a < 65536; a++) mem_known[a] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: halted steps, unused code, load extremes, then one of
      // every instruction from the reset origin.
      queue_execute();
      queue_item(OpUnused, 16'hFFFF, 16'hFFFF);
      queue_item(lc3_pkg::OP_LOAD, 16'h0000, 16'h0000);
      queue_item(lc3_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF);
      queue_item(lc3_pkg::OP_START, 16'h0000, 16'h0000);
      run_word(16'h1020);   // ADD R0, R0, #0 on the reset value
      run_word(16'h103F);   // ADD R0, R0, #-1
      run_word(16'h5240);   // AND R1, R1, R0
      run_word(16'h5260);   // AND R1, R1, #0 gives zero
      run_word(16'h947F);   // NOT R2, R1 gives negative
      run_word(16'h0002);   // BR with no condition bits is never taken
      run_word(16'h0E01);   // BRnzp skips one word
      run_word(16'hE5FF);   // LEA R2 leaves the codes alone
      run_word(16'h4BFE);   // JSR forward by 1022
      run_word(16'h3602);   // ST R3
      run_word(16'h2801);   // LD R4
      run_word(16'hBA03);   // STI R5
      run_word(16'hAC03);   // LDI R6
      run_word(16'h7E81);   // STR R7 at R2 + 1
      run_word(16'h6081);   // LDR R0 at R2 + 1
      run_word(16'h41C0);   // JSRR R7: base read before link write
      run_word(16'hC080);   // JMP R2
      run_word(16'h8000);   // RTI does nothing
      run_word(16'hD123);   // reserved opcode
      run_word(16'hF020);   // TRAP with another vector
      run_word({lc3_pkg::OPC_TRAP, 4'h0, lc3_pkg::HaltVector});
      queue_execute();
      wait_idle();

      // Random programs under several origins, the extremes among them.
      origins = '{16'h0000, 16'hFFFF, 16'($urandom), lc3_pkg::PcReset};
      foreach (origins[p]) begin
         write_origin(origins[p]);
         target = queued_items + RandomItems / 4;
         while (queued_items < target) begin
            pick = $urandom_range(0, 99);
            if (!is_running && pick < 40)
               queue_item(lc3_pkg::OP_START, 16'($urandom), 16'($urandom));
            else if (pick < 5)
               queue_item(lc3_pkg::OP_START, 16'($urandom), 16'($urandom));
            else if (pick < 12)
               queue_item(lc3_pkg::OP_LOAD, 16'($urandom), 16'($urandom));
            else if (pick < 15) queue_item(OpUnused, 16'($urandom), 16'($urandom));
            else if (pick < 45) run_word(random_instruction());
            else queue_execute();
         end
         wait_idle();
      end

      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* sim.f */
sv/lc3_pkg.sv
sv/lc3_ram.sv
sv/lc3_ctrl.sv
sv/lc3_dp.sv
sv/lc3_instruction_executor_top.sv
tb/sv/lc3_instruction_executor_top_test.sv
